FILE: sv/cslv_pkg.sv
package cslv_pkg;

    // item kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // bus channels
    localparam logic [1:0] CH0 = 2'd0;
    localparam logic [1:0] CH1 = 2'd1;
    localparam logic [1:0] CH2 = 2'd2;
    localparam logic [1:0] CH3 = 2'd3;

    // command opcodes
    localparam logic [7:0] OP_POS_BASE = 8'hc0;
    localparam logic [7:0] OP_MUTE     = 8'h82;
    localparam logic [7:0] OP_UNMUTE   = 8'h83;
    localparam logic [7:0] OP_REQ_B0   = 8'hb0;
    localparam logic [7:0] OP_REQ_B1   = 8'hb1;
    localparam logic [7:0] OP_EXT      = 8'hf0;
    localparam logic [7:0] OP_STAT_F3  = 8'hf3;
    localparam logic [7:0] OP_STAT_F4  = 8'hf4;
    localparam logic [7:0] OP_STATUS   = 8'hf6;
    localparam logic [7:0] OP_POLL     = 8'hf7;
    localparam logic [7:0] OP_IRQ_EN   = 8'hfa;
    localparam logic [7:0] OP_NONE     = 8'h00;

    // command buffer geometry
    localparam int         CMD_DEPTH  = 17;
    localparam int         LCD_DEPTH  = 16;
    localparam logic [4:0] CMD_FULL   = 5'd17;
    localparam logic [4:0] LEN_POS    = 5'd3;
    localparam logic [4:0] LEN_REQ    = 5'd4;

    // read byte on an empty reply queue
    localparam logic [7:0] EMPTY_BYTE = 8'hff;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] channel;
        logic [7:0] wdata;
        logic [9:0] sample_x;
        logic [9:0] sample_y;
        logic [3:0] sample_buttons;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic       audio_on;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
    } result_t;

endpackage

FILE: sv/cslv_item_if.sv
interface cslv_item_if;
    logic               valid;
    logic               ready;
    cslv_pkg::item_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cslv_res_if.sv
interface cslv_res_if;
    logic               valid;
    logic               ready;
    cslv_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cslv_res_fifo.sv
module cslv_res_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cslv_pkg::result_t push_data,
    output logic              full,
    cslv_res_if.source        res
);
    import cslv_pkg::*;

    result_t    slot0_reg;
    result_t    slot1_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    // two-entry result queue, head always in slot 0
    assign pop       = res.valid && res.ready;
    assign full      = (count_reg == 2'd2);
    assign res.valid = (count_reg != 2'd0);
    assign res.data  = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= (count_reg == 2'd2) ? slot1_reg : push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= push_data;
            end
            else
            begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

FILE: sv/command_slave_with_pointer_readback.sv
// Four-channel host-command slave with pointer readback.
// Input channel "item" carries one beat per bus write, bus read or pointer
// sample; output channel "res" returns exactly one beat per item with the
// read byte (0xff on an empty reply queue, 0 for anything but a read), the
// interrupt level, the audio enable and the relative pointer position.
// The result beat of an accepted item is registered in the result queue at the
// accept edge and is valid right after that edge. Throughput: one item per cycle
// while the result queue is not full; all state is updated by one level of decode at the accept edge.
// A two-entry result queue sits on the output, so input ready only drops
// when two result beats wait unread; a stalled receiver therefore holds
// off new items after two beats and nothing is lost or duplicated.
// Reset (rst_n low, asynchronous) empties the result queue, clears the
// command buffer, reply queues, pointer state and irq, and sets audio on.
module command_slave_with_pointer_readback (
    input  logic       clk,
    input  logic       rst_n,
    cslv_item_if.sink  item,
    cslv_res_if.source res
);
    import cslv_pkg::*;

    // reply queues, one per channel
    logic [7:0] reply_bytes_reg  [4][4];
    logic [7:0] reply_bytes_next [4][4];
    logic [1:0] reply_index_reg  [4];
    logic [1:0] reply_index_next [4];
    logic [2:0] reply_count_reg  [4];
    logic [2:0] reply_count_next [4];
    logic [7:0] reply_opcode_reg [4];
    logic [7:0] reply_opcode_next[4];

    // command gathering
    logic [7:0] cmd_bytes_reg  [CMD_DEPTH];
    logic [7:0] cmd_bytes_next [CMD_DEPTH];
    logic [4:0] cmd_index_reg;
    logic [4:0] cmd_index_next;
    logic [4:0] cmd_length_reg;
    logic [4:0] cmd_length_next;
    logic [7:0] lcd_bytes_reg  [LCD_DEPTH];
    logic [7:0] lcd_bytes_next [LCD_DEPTH];

    // flags
    logic       polling_on_reg;
    logic       polling_on_next;
    logic       bus_irq_enable_reg;
    logic       bus_irq_enable_next;
    logic       irq_reg;
    logic       irq_next;
    logic       audio_reg;
    logic       audio_next;

    // pointer
    logic [9:0] last_x_reg;
    logic [9:0] last_x_next;
    logic [9:0] last_y_reg;
    logic [9:0] last_y_next;
    logic       have_last_reg;
    logic       have_last_next;
    logic [9:0] rel_x_reg;
    logic [9:0] rel_x_next;
    logic [9:0] rel_y_reg;
    logic [9:0] rel_y_next;

    // per-item scratch
    logic       accept;
    logic       full;
    logic       clear_cmd;
    logic       q_en;
    logic [1:0] q_ch;
    logic [2:0] q_cnt;
    logic [7:0] q_bytes [4];
    logic [7:0] q_op;
    logic       q_raise;
    logic [7:0] rdata_c;
    logic [1:0] rd_idx;
    logic [9:0] old_x;
    logic [9:0] old_y;
    result_t    result_c;

    assign item.ready = !full;
    assign accept     = item.valid && item.ready;

    // next-state decode for the accepted item
    always_comb
    begin
        reply_bytes_next    = reply_bytes_reg;
        reply_index_next    = reply_index_reg;
        reply_count_next    = reply_count_reg;
        reply_opcode_next   = reply_opcode_reg;
        cmd_bytes_next      = cmd_bytes_reg;
        cmd_index_next      = cmd_index_reg;
        cmd_length_next     = cmd_length_reg;
        lcd_bytes_next      = lcd_bytes_reg;
        polling_on_next     = polling_on_reg;
        bus_irq_enable_next = bus_irq_enable_reg;
        irq_next            = irq_reg;
        audio_next          = audio_reg;
        last_x_next         = last_x_reg;
        last_y_next         = last_y_reg;
        have_last_next      = have_last_reg;
        rel_x_next          = rel_x_reg;
        rel_y_next          = rel_y_reg;
        clear_cmd           = 1'b0;
        q_en                = 1'b0;
        q_ch                = CH0;
        q_cnt               = 3'd2;
        q_bytes             = '{default: '0};
        q_op                = OP_NONE;
        q_raise             = 1'b0;
        rdata_c             = 8'h00;
        rd_idx              = reply_index_reg[item.data.channel];
        old_x               = have_last_reg ? last_x_reg : item.data.sample_x;
        old_y               = have_last_reg ? last_y_reg : item.data.sample_y;

        if (accept)
        begin
            case (item.data.kind)
                KIND_WRITE:
                begin
                    if (cmd_index_reg != 5'd0)
                    begin
                        // continuation byte
                        if (cmd_index_reg < CMD_FULL)
                        begin
                            cmd_bytes_next[cmd_index_reg] = item.data.wdata;
                            cmd_index_next = cmd_index_reg + 5'd1;
                        end
                        if (cmd_index_next == cmd_length_reg)
                        begin
                            unique case (item.data.channel)
                                CH0:
                                begin
                                    if (cmd_bytes_next[0] >= OP_POS_BASE)
                                    begin
                                        rel_y_next = {cmd_bytes_next[1][3:0],
                                                      cmd_bytes_next[0][5:0]};
                                        rel_x_next = {cmd_bytes_next[1][6:4], 7'd0}
                                                   | {2'd0, cmd_bytes_next[2]};
                                        clear_cmd  = 1'b1;
                                    end
                                end
                                CH1:
                                begin
                                    if (cmd_bytes_next[0] == OP_EXT)
                                    begin
                                        for (int i = 0; i < LCD_DEPTH; i++)
                                        begin
                                            lcd_bytes_next[i] = cmd_bytes_next[i + 1];
                                        end
                                    end
                                    clear_cmd = 1'b1;
                                end
                                CH2:
                                begin
                                    if (cmd_bytes_next[0] == OP_EXT)
                                    begin
                                        for (int i = 1; i < CMD_DEPTH; i++)
                                        begin
                                            cmd_bytes_next[i] = 8'h00;
                                        end
                                        cmd_length_next = CMD_FULL;
                                    end
                                    else
                                    begin
                                        clear_cmd = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    clear_cmd = 1'b1;
                                    if (cmd_bytes_next[0] == OP_REQ_B0)
                                    begin
                                        q_en    = 1'b1;
                                        q_ch    = CH3;
                                        q_cnt   = 3'd4;
                                        q_bytes = '{OP_REQ_B0, 8'h00, 8'h02, 8'h15};
                                        q_op    = OP_REQ_B0;
                                        q_raise = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    else if (item.data.channel == CH1)
                    begin
                        clear_cmd = 1'b1;
                    end
                    else
                    begin
                        // first byte of a command
                        cmd_bytes_next[0] = item.data.wdata;
                        cmd_index_next    = 5'd1;
                        unique case (item.data.channel)
                            CH0:
                            begin
                                if (item.data.wdata >= OP_POS_BASE)
                                begin
                                    cmd_length_next = LEN_POS;
                                end
                                else
                                begin
                                    cmd_index_next = 5'd0;
                                end
                            end
                            CH2:
                            begin
                                unique case (item.data.wdata)
                                    OP_MUTE:
                                    begin
                                        audio_next      = 1'b0;
                                        cmd_index_next  = 5'd0;
                                        cmd_length_next = 5'd0;
                                    end
                                    OP_UNMUTE:
                                    begin
                                        audio_next      = 1'b1;
                                        cmd_index_next  = 5'd0;
                                        cmd_length_next = 5'd0;
                                    end
                                    OP_EXT:
                                    begin
                                        cmd_length_next = CMD_FULL;
                                    end
                                    default:
                                    begin
                                        clear_cmd = 1'b1;
                                    end
                                endcase
                            end
                            default:
                            begin
                                unique case (item.data.wdata) inside
                                    OP_REQ_B0, OP_REQ_B1:
                                    begin
                                        cmd_length_next = LEN_REQ;
                                    end
                                    OP_EXT:
                                    begin
                                        q_en           = 1'b1;
                                        q_bytes        = '{OP_EXT, 8'h32, 8'h31, 8'h00};
                                        q_raise        = 1'b1;
                                        cmd_index_next = 5'd0;
                                    end
                                    OP_STAT_F3:
                                    begin
                                        q_en           = 1'b1;
                                        q_bytes        = '{OP_STAT_F3, 8'h01, 8'h00, 8'h00};
                                        q_raise        = 1'b1;
                                        cmd_index_next = 5'd0;
                                    end
                                    OP_STAT_F4:
                                    begin
                                        q_en           = 1'b1;
                                        q_bytes        = '{OP_STAT_F4, 8'h00, 8'h00, 8'h00};
                                        q_raise        = 1'b1;
                                        cmd_index_next = 5'd0;
                                    end
                                    OP_STATUS:
                                    begin
                                        q_en           = 1'b1;
                                        q_bytes        = '{OP_STATUS, 8'h02, 8'h00, 8'h00};
                                        cmd_index_next = 5'd0;
                                    end
                                    OP_POLL:
                                    begin
                                        polling_on_next = 1'b1;
                                        cmd_index_next  = 5'd0;
                                    end
                                    OP_IRQ_EN:
                                    begin
                                        bus_irq_enable_next = 1'b1;
                                        cmd_index_next      = 5'd0;
                                    end
                                    default:
                                    begin
                                        clear_cmd = 1'b1;
                                    end
                                endcase
                                q_ch = CH2;
                                q_op = item.data.wdata;
                            end
                        endcase
                    end
                end
                KIND_READ:
                begin
                    if (reply_count_reg[item.data.channel] == 3'd0)
                    begin
                        rdata_c = EMPTY_BYTE;
                    end
                    else
                    begin
                        rdata_c = reply_bytes_reg[item.data.channel][rd_idx];
                        // first byte of some replies acknowledges the interrupt
                        if (rd_idx == 2'd0)
                        begin
                            case (reply_opcode_reg[item.data.channel]) inside
                                OP_REQ_B0, OP_REQ_B1, OP_EXT, OP_STAT_F3, OP_STAT_F4,
                                OP_POLL:
                                begin
                                    irq_next = 1'b0;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        reply_index_next[item.data.channel] = rd_idx + 2'd1;
                        reply_count_next[item.data.channel] =
                            reply_count_reg[item.data.channel] - 3'd1;
                        if (reply_count_reg[item.data.channel] == 3'd1)
                        begin
                            reply_index_next[item.data.channel]  = 2'd0;
                            reply_opcode_next[item.data.channel] = OP_NONE;
                            reply_bytes_next[item.data.channel]  = '{default: '0};
                        end
                    end
                end
                KIND_SAMPLE:
                begin
                    last_x_next    = item.data.sample_x;
                    last_y_next    = item.data.sample_y;
                    have_last_next = 1'b1;
                    rel_x_next     = rel_x_reg + item.data.sample_x - old_x;
                    rel_y_next     = rel_y_reg + item.data.sample_y - old_y;
                    // polled pointer report
                    if (polling_on_reg)
                    begin
                        q_en    = 1'b1;
                        q_ch    = CH0;
                        q_cnt   = 3'd4;
                        q_bytes = '{{item.data.sample_buttons, 1'b0, rel_x_next[9:7]},
                                    {1'b0, rel_x_next[6:0]},
                                    {5'd0, rel_y_next[9:7]},
                                    {1'b0, rel_y_next[6:0]}};
                        q_op    = OP_POLL;
                        q_raise = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // command buffer clear
        if (clear_cmd)
        begin
            cmd_bytes_next  = '{default: '0};
            cmd_index_next  = 5'd0;
            cmd_length_next = 5'd0;
        end

        // reply queue load
        if (q_en)
        begin
            reply_index_next[q_ch]  = 2'd0;
            reply_count_next[q_ch]  = q_cnt;
            reply_bytes_next[q_ch]  = q_bytes;
            reply_opcode_next[q_ch] = q_op;
            if (q_raise)
            begin
                irq_next = 1'b1;
            end
        end
    end

    // result beat
    always_comb
    begin
        result_c.rdata    = rdata_c;
        result_c.irq      = irq_next;
        result_c.audio_on = audio_next;
        result_c.pos_x    = rel_x_next;
        result_c.pos_y    = rel_y_next;
    end

    // block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_bytes_reg    <= '{default: '{default: '0}};
            reply_index_reg    <= '{default: '0};
            reply_count_reg    <= '{default: '0};
            reply_opcode_reg   <= '{default: '0};
            cmd_bytes_reg      <= '{default: '0};
            cmd_index_reg      <= 5'd0;
            cmd_length_reg     <= 5'd0;
            lcd_bytes_reg      <= '{default: '0};
            polling_on_reg     <= 1'b0;
            bus_irq_enable_reg <= 1'b0;
            irq_reg            <= 1'b0;
            audio_reg          <= 1'b1;
            last_x_reg         <= 10'd0;
            last_y_reg         <= 10'd0;
            have_last_reg      <= 1'b0;
            rel_x_reg          <= 10'd0;
            rel_y_reg          <= 10'd0;
        end
        else
        begin
            reply_bytes_reg    <= reply_bytes_next;
            reply_index_reg    <= reply_index_next;
            reply_count_reg    <= reply_count_next;
            reply_opcode_reg   <= reply_opcode_next;
            cmd_bytes_reg      <= cmd_bytes_next;
            cmd_index_reg      <= cmd_index_next;
            cmd_length_reg     <= cmd_length_next;
            lcd_bytes_reg      <= lcd_bytes_next;
            polling_on_reg     <= polling_on_next;
            bus_irq_enable_reg <= bus_irq_enable_next;
            irq_reg            <= irq_next;
            audio_reg          <= audio_next;
            last_x_reg         <= last_x_next;
            last_y_reg         <= last_y_next;
            have_last_reg      <= have_last_next;
            rel_x_reg          <= rel_x_next;
            rel_y_reg          <= rel_y_next;
        end
    end

    // output queue
    cslv_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result_c),
        .full      (full),
        .res       (res)
    );

endmodule

FILE: bench/command_slave_with_pointer_readback_tb.sv
`timescale 1ns / 100ps

module command_slave_with_pointer_readback_tb;

    import cslv_pkg::*;

    // kind code that the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    cslv_item_if item_ch();
    cslv_res_if  res_ch();

    command_slave_with_pointer_readback u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .res   (res_ch)
    );

    // clock
    always #10 clk = ~clk;

    // idle rates in percent, changed between phases
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int mismatches;

    // status beats still owed by the block, oldest first
    result_t status_due[$];

    // mirror of the slave's state
    logic [7:0] rep_byte [16];
    logic [1:0] rep_idx  [4];
    logic [2:0] rep_cnt  [4];
    logic [7:0] rep_op   [4];
    logic [7:0] cmd_buf  [CMD_DEPTH];
    logic [4:0] cmd_idx;
    logic [4:0] cmd_len;
    logic       poll_en;
    logic       bus_irq_en;
    logic [7:0] lcd_mem  [LCD_DEPTH];
    logic [9:0] abs_x;
    logic [9:0] abs_y;
    logic       seen_sample;
    logic [9:0] rel_x;
    logic [9:0] rel_y;
    logic       irq_q;
    logic       audio_q;

    function automatic void cmd_clear();
        foreach (cmd_buf[i])
            cmd_buf[i] = 8'h00;
        cmd_idx = '0;
        cmd_len = '0;
    endfunction

    function automatic void mirror_reset();
        foreach (rep_byte[i])
            rep_byte[i] = 8'h00;
        for (int c = 0; c < 4; c++)
        begin
            rep_idx[c] = '0;
            rep_cnt[c] = '0;
            rep_op[c]  = OP_NONE;
        end
        foreach (lcd_mem[i])
            lcd_mem[i] = 8'h00;
        cmd_clear();
        poll_en     = 1'b0;
        bus_irq_en  = 1'b0;
        abs_x       = '0;
        abs_y       = '0;
        seen_sample = 1'b0;
        rel_x       = '0;
        rel_y       = '0;
        irq_q       = 1'b0;
        audio_q     = 1'b1;
    endfunction

    // load a readback reply into one channel's queue
    function automatic void reply_load(input logic [1:0] ch, input logic [2:0] n,
                                       input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic [7:0] op, input logic raise);
        rep_idx[ch] = '0;
        rep_cnt[ch] = n;
        rep_byte[{ch, 2'd0}] = b0;
        rep_byte[{ch, 2'd1}] = b1;
        rep_byte[{ch, 2'd2}] = b2;
        rep_byte[{ch, 2'd3}] = b3;
        rep_op[ch] = op;
        if (raise)
            irq_q = 1'b1;
    endfunction

    // command gathering and decode of one written byte
    function automatic void host_write(input logic [1:0] ch, input logic [7:0] d);
        if (cmd_idx != 0)
        begin
            if (cmd_idx < CMD_FULL)
            begin
                cmd_buf[cmd_idx] = d;
                cmd_idx = cmd_idx + 5'd1;
            end
            if (cmd_idx != cmd_len)
                return;
            case (ch)
                CH0:
                begin
                    if (cmd_buf[0] >= OP_POS_BASE)
                    begin
                        rel_y = {cmd_buf[1][3:0], cmd_buf[0][5:0]};
                        rel_x = {cmd_buf[1][6:4], 7'd0} | {2'd0, cmd_buf[2]};
                        cmd_clear();
                    end
                end
                CH1:
                begin
                    if (cmd_buf[0] == OP_EXT)
                        for (int i = 0; i < LCD_DEPTH; i++)
                            lcd_mem[i] = cmd_buf[i + 1];
                    cmd_clear();
                end
                CH2:
                begin
                    if (cmd_buf[0] == OP_EXT)
                    begin
                        for (int i = 1; i < CMD_DEPTH; i++)
                            cmd_buf[i] = 8'h00;
                        cmd_len = CMD_FULL;
                    end
                    else
                        cmd_clear();
                end
                default:
                begin
                    if (cmd_buf[0] == OP_REQ_B0)
                    begin
                        cmd_clear();
                        reply_load(CH3, 3'd4, OP_REQ_B0, 8'h00, 8'h02, 8'h15, OP_REQ_B0, 1'b1);
                    end
                    else
                        cmd_clear();
                end
            endcase
            return;
        end

        // first byte of a command
        if (ch == CH1)
        begin
            cmd_clear();
            return;
        end
        cmd_buf[0] = d;
        cmd_idx = 5'd1;
        if (ch == CH0)
        begin
            if (d >= OP_POS_BASE)
                cmd_len = LEN_POS;
            else
                cmd_idx = '0;
        end
        else if (ch == CH2)
        begin
            case (d)
                OP_MUTE:
                begin
                    audio_q = 1'b0;
                    cmd_idx = '0;
                    cmd_len = '0;
                end
                OP_UNMUTE:
                begin
                    audio_q = 1'b1;
                    cmd_idx = '0;
                    cmd_len = '0;
                end
                OP_EXT:  cmd_len = CMD_FULL;
                default: cmd_clear();
            endcase
        end
        else
        begin
            case (d)
                OP_REQ_B0, OP_REQ_B1: cmd_len = LEN_REQ;
                OP_EXT:
                begin
                    reply_load(CH2, 3'd2, OP_EXT, 8'h32, 8'h31, 8'h00, OP_EXT, 1'b1);
                    cmd_idx = '0;
                end
                OP_STAT_F3:
                begin
                    cmd_idx = '0;
                    reply_load(CH2, 3'd2, OP_STAT_F3, 8'h01, 8'h00, 8'h00, OP_STAT_F3, 1'b1);
                end
                OP_STAT_F4:
                begin
                    cmd_idx = '0;
                    reply_load(CH2, 3'd2, OP_STAT_F4, 8'h00, 8'h00, 8'h00, OP_STAT_F4, 1'b1);
                end
                OP_STATUS:
                begin
                    reply_load(CH2, 3'd2, OP_STATUS, 8'h02, 8'h00, 8'h00, OP_STATUS, 1'b0);
                    cmd_idx = '0;
                end
                OP_POLL:
                begin
                    poll_en = 1'b1;
                    cmd_idx = '0;
                end
                OP_IRQ_EN:
                begin
                    bus_irq_en = 1'b1;
                    cmd_idx = '0;
                end
                default: cmd_clear();
            endcase
        end
    endfunction

    // pop one reply byte, 0xff when the channel has nothing queued
    function automatic logic [7:0] host_read(input logic [1:0] ch);
        logic [7:0] b;
        logic [1:0] ix;
        if (rep_cnt[ch] == 0)
            return EMPTY_BYTE;
        ix = rep_idx[ch];
        b = rep_byte[{ch, ix}];
        if (ix == 0)
        begin
            case (rep_op[ch])
                OP_REQ_B0, OP_REQ_B1, OP_EXT, OP_STAT_F3, OP_STAT_F4, OP_POLL: irq_q = 1'b0;
                default: ;
            endcase
        end
        rep_idx[ch] = ix + 2'd1;
        rep_cnt[ch] = rep_cnt[ch] - 3'd1;
        if (rep_cnt[ch] == 0)
        begin
            rep_idx[ch] = '0;
            rep_op[ch]  = OP_NONE;
            for (int i = 0; i < 4; i++)
                rep_byte[{ch, 2'(i)}] = 8'h00;
        end
        return b;
    endfunction

    // relative pointer update and polled report
    function automatic void pointer_move(input logic [9:0] sx, input logic [9:0] sy,
                                         input logic [3:0] btn);
        logic [9:0] ox;
        logic [9:0] oy;
        ox = seen_sample ? abs_x : sx;
        oy = seen_sample ? abs_y : sy;
        abs_x = sx;
        abs_y = sy;
        seen_sample = 1'b1;
        rel_x = rel_x + sx - ox;
        rel_y = rel_y + sy - oy;
        if (poll_en)
            reply_load(CH0, 3'd4, {btn, 1'b0, rel_x[9:7]}, {1'b0, rel_x[6:0]},
                       {5'd0, rel_y[9:7]}, {1'b0, rel_y[6:0]}, OP_POLL, 1'b1);
    endfunction

    // status beat that one accepted item produces
    function automatic result_t apply_host_item(input item_t it);
        result_t r;
        logic [7:0] rd;
        rd = 8'h00;
        case (it.kind)
            KIND_WRITE:  host_write(it.channel, it.wdata);
            KIND_READ:   rd = host_read(it.channel);
            KIND_SAMPLE: pointer_move(it.sample_x, it.sample_y, it.sample_buttons);
            default: ;
        endcase
        r.rdata    = rd;
        r.irq      = irq_q;
        r.audio_on = audio_q;
        r.pos_x    = rel_x;
        r.pos_y    = rel_y;
        return r;
    endfunction

    // a request completed on channel 0 is never decoded and blocks all later writes
    function automatic logic [1:0] safe_channel(input logic [1:0] ch);
        logic [4:0] next_idx;
        next_idx = (cmd_idx < CMD_FULL) ? cmd_idx + 5'd1 : cmd_idx;
        if (ch == CH0 && cmd_idx != 0 && next_idx == cmd_len && cmd_buf[0] < OP_POS_BASE)
            return CH3;
        return ch;
    endfunction

    function automatic item_t random_filler();
        item_t it;
        it.kind           = KIND_WRITE;
        it.channel        = 2'($urandom_range(0, 3));
        it.wdata          = 8'($urandom_range(0, 255));
        it.sample_x       = 10'($urandom_range(0, 1023));
        it.sample_y       = 10'($urandom_range(0, 1023));
        it.sample_buttons = 4'($urandom_range(0, 15));
        return it;
    endfunction

    // one input beat; called at a falling edge, returns at a falling edge
    task automatic send_item(input item_t it);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        status_due.push_back(apply_host_item(it));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_write(input logic [1:0] ch, input logic [7:0] d);
        item_t it;
        it = random_filler();
        it.kind    = KIND_WRITE;
        it.channel = ch;
        it.wdata   = d;
        send_item(it);
    endtask

    task automatic send_read(input logic [1:0] ch);
        item_t it;
        it = random_filler();
        it.kind    = KIND_READ;
        it.channel = ch;
        send_item(it);
    endtask

    task automatic send_sample(input logic [9:0] x, input logic [9:0] y, input logic [3:0] btn);
        item_t it;
        it = random_filler();
        it.kind           = KIND_SAMPLE;
        it.sample_x       = x;
        it.sample_y       = y;
        it.sample_buttons = btn;
        send_item(it);
    endtask

    // hold the sender off until every owed beat is back
    task automatic wait_for_results();
        int guard;
        guard = 0;
        item_ch.valid <= 1'b0;
        while (status_due.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        @(negedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [9:0] want,
                                 input logic [9:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // receiver stalls
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // compare each status beat with the oldest owed one
    always @(posedge clk)
    begin : check_beat
        result_t want;
        result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (status_due.size() == 0)
                note_mismatch("beat with nothing owed", 10'd0, {2'd0, got.rdata});
            else
            begin
                want = status_due.pop_front();
                if (got.rdata !== want.rdata)
                    note_mismatch("rdata", 10'(want.rdata), 10'(got.rdata));
                if (got.irq !== want.irq)
                    note_mismatch("irq", 10'(want.irq), 10'(got.irq));
                if (got.audio_on !== want.audio_on)
                    note_mismatch("audio_on", 10'(want.audio_on), 10'(got.audio_on));
                if (got.pos_x !== want.pos_x)
                    note_mismatch("pos_x", want.pos_x, got.pos_x);
                if (got.pos_y !== want.pos_y)
                    note_mismatch("pos_y", want.pos_y, got.pos_y);
            end
        end
    end

    // reads of empty queues, the unused kind and bytes that start nothing
    task automatic test_idle_traffic();
        item_t it;
        send_read(CH1);
        it = random_filler();
        it.kind = KIND_UNUSED;
        send_item(it);
        send_write(CH1, 8'hff);
        send_write(CH0, 8'h3f);
    endtask

    task automatic test_audio();
        send_write(CH2, OP_MUTE);
        send_write(CH2, OP_UNMUTE);
    endtask

    // single-byte channel 3 commands; the status readback leaves irq alone
    task automatic test_readbacks();
        send_write(CH3, OP_STATUS);
        send_read(CH2);
        send_write(CH3, OP_EXT);
        send_read(CH2);
        send_write(CH3, OP_STAT_F3);
        send_write(CH3, OP_STAT_F4);
        send_write(CH3, OP_IRQ_EN);
    endtask

    task automatic test_position();
        repeat (3)
            send_write(CH0, 8'hff);
    endtask

    // four-byte request answered on channel 3
    task automatic test_request_reply();
        send_write(CH3, OP_REQ_B0);
        send_write(CH3, 8'h00);
        send_write(CH1, 8'hff);
        send_write(CH3, 8'h80);
        send_read(CH3);
    endtask

    // first sample does not move, wrap on the second, then a polled report
    task automatic test_pointer();
        send_sample(10'h3ff, 10'h000, 4'h0);
        send_sample(10'h000, 10'h3ff, 4'h0);
        send_write(CH3, OP_POLL);
        send_sample(10'h155, 10'h2aa, 4'hf);
    endtask

    task automatic send_item_noise();
        item_t it;
        it = random_filler();
        it.kind = 2'($urandom_range(0, 3));
        if (it.kind == KIND_WRITE)
            it.channel = safe_channel(it.channel);
        send_item(it);
    endtask

    // mostly well-formed command sequences with random content
    task automatic run_random_traffic(input int count);
        int stop_at;
        int pick;
        logic [7:0] op;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 14)
            begin
                // pointer position
                send_write(safe_channel(CH0), {2'b11, 6'($urandom_range(0, 63))});
                repeat (2)
                    send_write(safe_channel(($urandom_range(0, 4) == 0) ?
                               2'($urandom_range(0, 3)) : CH0), 8'($urandom_range(0, 255)));
            end
            else if (pick < 22)
            begin
                // lcd load, sometimes held full on channel 2 first
                send_write(safe_channel(CH2), OP_EXT);
                repeat (15)
                    send_write(safe_channel(2'($urandom_range(0, 3))),
                               8'($urandom_range(0, 255)));
                if ($urandom_range(0, 2) == 0)
                begin
                    send_write(safe_channel(CH2), 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(1, 3))
                        send_write(safe_channel(2'($urandom_range(0, 3))),
                                   8'($urandom_range(0, 255)));
                end
                else
                    send_write(safe_channel(CH1), 8'($urandom_range(0, 255)));
            end
            else if (pick < 30)
                send_write(safe_channel(CH2), $urandom_range(0, 1) ? OP_MUTE : OP_UNMUTE);
            else if (pick < 45)
            begin
                case ($urandom_range(0, 5))
                    0:       op = OP_EXT;
                    1:       op = OP_STAT_F3;
                    2:       op = OP_STAT_F4;
                    3:       op = OP_STATUS;
                    4:       op = OP_POLL;
                    default: op = OP_IRQ_EN;
                endcase
                send_write(safe_channel(CH3), op);
                repeat ($urandom_range(0, 3))
                    send_read(CH2);
            end
            else if (pick < 52)
            begin
                // four-byte request
                send_write(safe_channel(CH3), $urandom_range(0, 1) ? OP_REQ_B0 : OP_REQ_B1);
                repeat (2)
                    send_write(safe_channel(2'($urandom_range(0, 3))),
                               8'($urandom_range(0, 255)));
                send_write(safe_channel(($urandom_range(0, 3) == 0) ?
                           2'($urandom_range(0, 3)) : CH3), 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 5))
                    send_read(CH3);
            end
            else if (pick < 70)
            begin
                repeat ($urandom_range(1, 4))
                    send_read(2'($urandom_range(0, 3)));
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 4))
                    send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                                4'($urandom_range(0, 15)));
                repeat ($urandom_range(0, 4))
                    send_read(CH0);
            end
            else
            begin
                // noise
                send_item_noise();
            end
            if ($urandom_range(0, 59) == 0)
                wait_for_results();
        end
    endtask

    // request finished on channel 0: never decoded, later writes are swallowed
    task automatic test_stalled_command();
        send_write(CH3, OP_REQ_B1);
        send_write(CH3, 8'h00);
        send_write(CH2, 8'h55);
        send_write(CH0, 8'hc5);
        send_write(CH3, OP_EXT);
        send_write(CH2, OP_MUTE);
        send_write(CH1, 8'h00);
        send_read(CH2);
        send_sample(10'h200, 10'h001, 4'h5);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        res_ch.ready  = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 63;
        items_sent    = 0;
        mismatches    = 0;
        mirror_reset();

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_traffic();
        test_audio();
        test_readbacks();
        test_position();
        test_request_reply();
        test_pointer();
        run_random_traffic(300);
        wait_for_results();

        send_idle_pct = 63;
        recv_idle_pct = 8;
        run_random_traffic(320);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(300);
        test_stalled_command();
        wait_for_results();
        repeat (4)
            @(posedge clk);

        if (mismatches == 0 && status_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
sv/cslv_pkg.sv
sv/cslv_item_if.sv
sv/cslv_res_if.sv
sv/cslv_res_fifo.sv
sv/command_slave_with_pointer_readback.sv
bench/command_slave_with_pointer_readback_tb.sv
